>>> rtl/isdos_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// isdos_pkg
// Shared types and constants for the periodic square lattice Ising
// density-of-states enumerator.
// ----------------------------------------------------------------------------
package isdos_pkg;

   localparam int MAX_SITES = 31;
   localparam int SITE_W    = MAX_SITES;           // one bit per spin
   localparam int DIM_W     = 5;                   // lattice width / height field
   localparam int DIFF_W    = 2 * SITE_W;          // right bonds + down bonds
   localparam int ENERGY_W  = $clog2(DIFF_W + 1);  // unsatisfied bond count
   localparam int LEVEL_W   = ENERGY_W - 1;        // half the bond count
   localparam int LEVELS    = 1 << LEVEL_W;
   localparam int COUNT_W   = 32;
   localparam int PTR_W     = DIM_W + 1;

   typedef logic [SITE_W-1:0] site_vec_type;

   // lattice geometry held for the duration of one request
   typedef struct packed {
      logic [DIM_W-1:0] width;       // sites per row
      logic [DIM_W-1:0] wrap_shift;  // sites - width
      site_vec_type     site_mask;   // ones on the used sites
      site_vec_type     row_end;     // ones on the last site of each row
   } geom_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_RUN,
      ST_DRAIN,
      ST_EMIT,
      ST_ERROR
   } seq_state_type;

endpackage
`default_nettype wire

>>> rtl/isdos_bond_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// isdos_bond_stage
// First pipeline stage: marks every unsatisfied right and down bond of one
// spin configuration.
// ----------------------------------------------------------------------------
module isdos_bond_stage (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   in_valid,
   input  wire  isdos_pkg::site_vec_type         in_cfg,
   input  wire  isdos_pkg::geom_type             geom,
   output logic                                  out_valid,
   output logic [isdos_pkg::DIFF_W-1:0]          out_diff
);
   import isdos_pkg::*;

   site_vec_type             right_nb;
   site_vec_type             down_nb;
   logic                     valid_ff;
   logic                     valid_in;
   logic [DIFF_W-1:0]        diff_ff;
   logic [DIFF_W-1:0]        diff_in;

   always_comb begin
      // right neighbor wraps back to the row start at the row end
      right_nb = ((in_cfg >> 1) & ~geom.row_end)
               | ((in_cfg << (geom.width - DIM_W'(1))) & geom.row_end);
      // down neighbor is the site index plus width, modulo the site count
      down_nb  = ((in_cfg >> geom.width) | (in_cfg << geom.wrap_shift)) & geom.site_mask;
      diff_in  = {(in_cfg ^ down_nb) & geom.site_mask,
                  (in_cfg ^ right_nb) & geom.site_mask};
      valid_in = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      diff_ff <= diff_in;
   end

   assign out_valid = valid_ff;
   assign out_diff  = diff_ff;

endmodule
`default_nettype wire

>>> rtl/isdos_energy_count.sv
`default_nettype none
// ----------------------------------------------------------------------------
// isdos_energy_count
// Two-stage population count of the unsatisfied bond vector; yields the
// energy level (half the bond count).
// ----------------------------------------------------------------------------
module isdos_energy_count (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   in_valid,
   input  wire  [isdos_pkg::DIFF_W-1:0]          in_diff,
   output logic                                  out_valid,
   output logic [isdos_pkg::LEVEL_W-1:0]         out_level,
   output logic                                  out_busy
);
   import isdos_pkg::*;

   localparam int GROUP_W = 8;
   localparam int GROUPS  = (DIFF_W + GROUP_W - 1) / GROUP_W;
   localparam int PART_W  = $clog2(GROUP_W + 1);

   logic [GROUPS*GROUP_W-1:0] padded;
   logic [PART_W-1:0]         part_ff [GROUPS];
   logic [PART_W-1:0]         part_in [GROUPS];
   logic                      pv_ff;
   logic                      pv_in;
   logic [ENERGY_W-1:0]       total;
   logic [LEVEL_W-1:0]        level_ff;
   logic [LEVEL_W-1:0]        level_in;
   logic                      lv_ff;
   logic                      lv_in;

   // stage A: per-group counts
   always_comb begin
      padded = (GROUPS*GROUP_W)'(in_diff);
      for (int g = 0; g < GROUPS; g++) begin
         part_in[g] = '0;
         for (int b = 0; b < GROUP_W; b++) begin
            part_in[g] = part_in[g] + PART_W'(padded[g*GROUP_W + b]);
         end
      end
      pv_in = in_valid;
   end

   // stage B: add the group counts; bond count is always even on a torus
   always_comb begin
      total = '0;
      for (int g = 0; g < GROUPS; g++) begin
         total = total + ENERGY_W'(part_ff[g]);
      end
      level_in = total[ENERGY_W-1:1];
      lv_in    = pv_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
         lv_ff <= 1'b0;
      end else begin
         pv_ff <= pv_in;
         lv_ff <= lv_in;
      end
      part_ff  <= part_in;
      level_ff <= level_in;
   end

   assign out_valid = lv_ff;
   assign out_level = level_ff;
   // any configuration still inside either stage
   assign out_busy  = pv_ff | lv_ff;

endmodule
`default_nettype wire

>>> rtl/isdos_histogram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// isdos_histogram
// One counter per energy level, bumped by the pipeline and read out by the
// result sequencer.
// ----------------------------------------------------------------------------
module isdos_histogram (
   input  wire                                   clock,
   input  wire                                   clear,
   input  wire                                   inc_valid,
   input  wire  [isdos_pkg::LEVEL_W-1:0]         inc_level,
   input  wire  [isdos_pkg::LEVEL_W-1:0]         rd_level,
   output logic [isdos_pkg::COUNT_W-1:0]         rd_count
);
   import isdos_pkg::*;

   logic [COUNT_W-1:0] hist_ff [LEVELS];
   logic [COUNT_W-1:0] hist_in [LEVELS];

   always_comb begin
      for (int i = 0; i < LEVELS; i++) begin
         if (clear) begin
            hist_in[i] = '0;
         end else if (inc_valid && inc_level == LEVEL_W'(i)) begin
            hist_in[i] = hist_ff[i] + COUNT_W'(1);
         end else begin
            hist_in[i] = hist_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      hist_ff <= hist_in;
   end

   assign rd_count = hist_ff[rd_level];

endmodule
`default_nettype wire

>>> rtl/ising_square_dos_enumerator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ising_square_dos_enumerator
// Ising model density of states on a periodic square lattice by full
// enumeration of spin configurations.
// ----------------------------------------------------------------------------
// A request names the lattice width and height. With n = width*height sites
// (1..31), the block steps a counter through all 2^n spin configurations,
// one per cycle, into a four-stage pipeline (bond compare, two popcount
// stages, histogram bump) and then returns n+1 beats, energy levels 0..n,
// the last one flagged. A request runs through setup, enumeration of all
// 2^n configurations, a pipeline drain and the n+1 result beats. A zero
// dimension or more than 31 sites gives a single beat with status 1 and
// count 0.
// req_ready is high only while no request is in progress.
// ----------------------------------------------------------------------------
module ising_square_dos_enumerator (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_ready,
   input  wire  [isdos_pkg::DIM_W-1:0]           req_lattice_width,
   input  wire  [isdos_pkg::DIM_W-1:0]           req_lattice_height,
   output logic                                  rsp_valid,
   input  wire                                   rsp_ready,
   output logic [isdos_pkg::LEVEL_W-1:0]         rsp_energy_level,
   output logic [isdos_pkg::COUNT_W-1:0]         rsp_state_count,
   output logic                                  rsp_last_entry,
   output logic                                  rsp_status
);
   import isdos_pkg::*;

   seq_state_type          state_ff, state_in;
   site_vec_type           cfg_ff, cfg_in;
   logic [DIM_W-1:0]       width_ff, width_in;
   logic [DIM_W-1:0]       sites_ff, sites_in;
   site_vec_type           mask_ff, mask_in;
   site_vec_type           row_end_ff, row_end_in;
   logic [PTR_W-1:0]       ptr_ff, ptr_in;
   logic [LEVEL_W-1:0]     level_ff, level_in;

   logic [2*DIM_W-1:0]     area;
   logic                   too_big;
   logic                   hist_clear;
   logic                   run_valid;
   geom_type               geom;

   logic                   bond_valid;
   logic [DIFF_W-1:0]      bond_diff;
   logic                   cnt_valid;
   logic [LEVEL_W-1:0]     cnt_level;
   logic                   cnt_busy;
   logic                   pipe_busy;
   logic [COUNT_W-1:0]     rd_count;

   assign area    = (2*DIM_W)'(req_lattice_width) * (2*DIM_W)'(req_lattice_height);
   assign too_big = (req_lattice_width == '0) || (req_lattice_height == '0)
                 || (area > (2*DIM_W)'(MAX_SITES));

   assign geom.width      = width_ff;
   assign geom.wrap_shift = sites_ff - width_ff;
   assign geom.site_mask  = mask_ff;
   assign geom.row_end    = row_end_ff;

   assign pipe_busy = run_valid | bond_valid | cnt_busy;

   always_comb begin
      state_in   = state_ff;
      cfg_in     = cfg_ff;
      width_in   = width_ff;
      sites_in   = sites_ff;
      mask_in    = mask_ff;
      row_end_in = row_end_ff;
      ptr_in     = ptr_ff;
      level_in   = level_ff;
      hist_clear = 1'b0;
      run_valid  = 1'b0;
      req_ready  = 1'b0;
      rsp_valid        = 1'b0;
      rsp_energy_level = '0;
      rsp_state_count  = '0;
      rsp_last_entry   = 1'b0;
      rsp_status       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               hist_clear = 1'b1;
               width_in   = req_lattice_width;
               sites_in   = area[DIM_W-1:0];
               mask_in    = ~({SITE_W{1'b1}} << area[DIM_W-1:0]);
               row_end_in = '0;
               ptr_in     = PTR_W'(req_lattice_width) - PTR_W'(1);
               cfg_in     = '0;
               state_in   = too_big ? ST_ERROR : ST_SETUP;
            end
         end
         ST_SETUP: begin
            // mark the last site of each row, one row per cycle
            if (ptr_ff < PTR_W'(sites_ff)) begin
               row_end_in[ptr_ff[DIM_W-1:0]] = 1'b1;
               ptr_in = ptr_ff + PTR_W'(width_ff);
            end else begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            run_valid = 1'b1;
            cfg_in    = cfg_ff + SITE_W'(1);
            if (cfg_ff == mask_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!pipe_busy) begin
               level_in = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_valid        = 1'b1;
            rsp_energy_level = level_ff;
            rsp_state_count  = rd_count;
            rsp_last_entry   = (level_ff == sites_ff);
            if (rsp_ready) begin
               if (level_ff == sites_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  level_in = level_ff + LEVEL_W'(1);
               end
            end
         end
         ST_ERROR: begin
            rsp_valid      = 1'b1;
            rsp_last_entry = 1'b1;
            rsp_status     = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cfg_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cfg_ff   <= cfg_in;
      end
      width_ff   <= width_in;
      sites_ff   <= sites_in;
      mask_ff    <= mask_in;
      row_end_ff <= row_end_in;
      ptr_ff     <= ptr_in;
      level_ff   <= level_in;
   end

   isdos_bond_stage u_bond (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (run_valid),
      .in_cfg    (cfg_ff),
      .geom      (geom),
      .out_valid (bond_valid),
      .out_diff  (bond_diff)
   );

   isdos_energy_count u_count (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (bond_valid),
      .in_diff   (bond_diff),
      .out_valid (cnt_valid),
      .out_level (cnt_level),
      .out_busy  (cnt_busy)
   );

   isdos_histogram u_hist (
      .clock     (clock),
      .clear     (hist_clear),
      .inc_valid (cnt_valid),
      .inc_level (cnt_level),
      .rd_level  (level_ff),
      .rd_count  (rd_count)
   );

endmodule
`default_nettype wire
